// ===== hw/rtl/kbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyboard report package
// Shared constants, command and report types and the scan-code ROM of the
// keycode to HID boot-keyboard report core.
// ----------------------------------------------------------------------------
`default_nettype none

package kbr_pkg;

  // Slot geometry
  localparam int KEY_SLOTS = 6;
  localparam int OUT_SLOTS = 6;

  // Field widths
  localparam int USAGE_W    = 8;
  localparam int SCAN_W     = 8;
  localparam int TICK_W     = 20;
  localparam int INTERVAL_W = 16;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_INDEX_W = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_REPORT_INTERVAL = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STUCK_TIMEOUT   = 1'b1;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] REPORT_INTERVAL_RST = 16'd1000;
  localparam logic [TICK_W-1:0]     STUCK_TIMEOUT_RST   = 20'd300000;

  // Saturation value of the tick counter
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Modifier usage range
  localparam logic [USAGE_W-1:0] MOD_FIRST = 8'hE0;
  localparam logic [USAGE_W-1:0] MOD_LAST  = 8'hE7;

  // Input opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Command queue depth
  localparam int CMD_FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_MOD,
    CMD_PRESS,
    CMD_RELEASE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic [USAGE_W-1:0]   usage;
    logic                 down;
    logic                 ready;
  } cmd_t;

  typedef struct packed {
    logic [USAGE_W-1:0]                mods;
    logic [OUT_SLOTS-1:0][USAGE_W-1:0] keys;
  } report_t;

  // Translate a host scan code to a HID usage; zero means unknown
  function automatic logic [USAGE_W-1:0] scan_to_usage(input logic [SCAN_W-1:0] scan);
    logic [USAGE_W-1:0] u;
    case (scan)
      8'd30:  u = 8'h04;
      8'd48:  u = 8'h05;
      8'd46:  u = 8'h06;
      8'd32:  u = 8'h07;
      8'd18:  u = 8'h08;
      8'd33:  u = 8'h09;
      8'd34:  u = 8'h0A;
      8'd35:  u = 8'h0B;
      8'd23:  u = 8'h0C;
      8'd36:  u = 8'h0D;
      8'd37:  u = 8'h0E;
      8'd38:  u = 8'h0F;
      8'd50:  u = 8'h10;
      8'd49:  u = 8'h11;
      8'd24:  u = 8'h12;
      8'd25:  u = 8'h13;
      8'd16:  u = 8'h14;
      8'd19:  u = 8'h15;
      8'd31:  u = 8'h16;
      8'd20:  u = 8'h17;
      8'd22:  u = 8'h18;
      8'd47:  u = 8'h19;
      8'd17:  u = 8'h1A;
      8'd45:  u = 8'h1B;
      8'd21:  u = 8'h1C;
      8'd44:  u = 8'h1D;
      8'd2:   u = 8'h1E;
      8'd3:   u = 8'h1F;
      8'd4:   u = 8'h20;
      8'd5:   u = 8'h21;
      8'd6:   u = 8'h22;
      8'd7:   u = 8'h23;
      8'd8:   u = 8'h24;
      8'd9:   u = 8'h25;
      8'd10:  u = 8'h26;
      8'd11:  u = 8'h27;
      8'd28:  u = 8'h28;
      8'd1:   u = 8'h29;
      8'd14:  u = 8'h2A;
      8'd15:  u = 8'h2B;
      8'd57:  u = 8'h2C;
      8'd59:  u = 8'h3A;
      8'd60:  u = 8'h3B;
      8'd61:  u = 8'h3C;
      8'd62:  u = 8'h3D;
      8'd63:  u = 8'h3E;
      8'd64:  u = 8'h3F;
      8'd65:  u = 8'h40;
      8'd66:  u = 8'h41;
      8'd67:  u = 8'h42;
      8'd68:  u = 8'h43;
      8'd87:  u = 8'h44;
      8'd88:  u = 8'h45;
      8'd106: u = 8'h4F;
      8'd105: u = 8'h50;
      8'd108: u = 8'h51;
      8'd103: u = 8'h52;
      8'd29:  u = 8'hE0;
      8'd42:  u = 8'hE1;
      8'd56:  u = 8'hE2;
      8'd125: u = 8'hE3;
      8'd97:  u = 8'hE4;
      8'd54:  u = 8'hE5;
      8'd100: u = 8'hE6;
      8'd126: u = 8'hE7;
      default: u = '0;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kbr_front.sv =====
// ----------------------------------------------------------------------------
// Keyboard report front end
// Translates scan codes and classifies each input beat into a command for
// the back end. Unknown scan codes are dropped here.
// ----------------------------------------------------------------------------
`default_nettype none

module kbr_front (
  input  wire logic                        in_opcode,
  input  wire logic [kbr_pkg::SCAN_W-1:0]  in_scan_code,
  input  wire logic                        in_key_down,
  input  wire logic                        in_host_ready,
  input  wire logic                        in_beat,
  output kbr_pkg::cmd_t                    cmd,
  output logic                             cmd_push
);

  logic [kbr_pkg::USAGE_W-1:0] usage;

  // Look up the usage
  assign usage = kbr_pkg::scan_to_usage(in_scan_code);

  // Classify the beat
  always_comb begin
    cmd.usage = usage;
    cmd.down  = in_key_down;
    cmd.ready = in_host_ready;
    cmd.op    = kbr_pkg::CMD_TICK;
    cmd_push  = 1'b0;
    if (in_beat) begin
      if (in_opcode == kbr_pkg::OP_TICK) begin
        cmd.op   = kbr_pkg::CMD_TICK;
        cmd_push = 1'b1;
      end else if (usage != '0) begin
        cmd_push = 1'b1;
        if (usage inside {[kbr_pkg::MOD_FIRST:kbr_pkg::MOD_LAST]}) begin
          cmd.op = kbr_pkg::CMD_MOD;
        end else if (in_key_down) begin
          cmd.op = kbr_pkg::CMD_PRESS;
        end else begin
          cmd.op = kbr_pkg::CMD_RELEASE;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kbr_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// Keyboard report command queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kbr_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire kbr_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output kbr_pkg::cmd_t      pop_data,
  output logic               valid
);

  localparam int DEPTH = kbr_pkg::CMD_FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kbr_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kbr_back.sv =====
// ----------------------------------------------------------------------------
// Keyboard report back end
// Holds key and modifier state, tick count and config; runs one command
// per cycle while the report slot is free or popped; registers reports.
// ----------------------------------------------------------------------------
`default_nettype none

module kbr_back #(
  parameter int KEY_SLOTS = kbr_pkg::KEY_SLOTS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [kbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [kbr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              cmd_valid,
  input  wire kbr_pkg::cmd_t                     cmd,
  output logic                                   cmd_pop,
  input  wire logic                              out_pop,
  output logic                                   out_empty,
  output kbr_pkg::report_t                       report
);

  localparam int UW = kbr_pkg::USAGE_W;
  localparam int TW = kbr_pkg::TICK_W;
  localparam int IW = kbr_pkg::INTERVAL_W;

  logic [IW-1:0] interval_r;
  logic [TW-1:0] timeout_r;

  logic [UW-1:0] held_r [KEY_SLOTS];
  logic [UW-1:0] held_nxt [KEY_SLOTS];
  logic [UW-1:0] sent_r [KEY_SLOTS];
  logic [UW-1:0] sent_nxt [KEY_SLOTS];
  logic [UW-1:0] held_mod_r, held_mod_nxt;
  logic [UW-1:0] sent_mod_r, sent_mod_nxt;
  logic [TW-1:0] ticks_r, ticks_nxt;

  logic             out_valid_r, out_valid_nxt;
  kbr_pkg::report_t report_r, report_nxt;

  logic          run;
  logic [TW-1:0] ticks_inc;
  logic          busy, hit, passed, differ, can_send;
  logic [UW-1:0] mod_bit;

  // Take a command when the report slot is free or drains this cycle
  assign run       = cmd_valid && (!out_valid_r || out_pop);
  assign cmd_pop   = run;
  assign out_empty = !out_valid_r;
  assign report    = report_r;

  assign ticks_inc = (ticks_r != kbr_pkg::TICK_MAX) ? ticks_r + 1'b1 : ticks_r;
  assign mod_bit   = UW'(1) << cmd.usage[2:0];
  assign can_send  = cmd.ready && (ticks_r >= {{(TW - IW){1'b0}}, interval_r});

  // Apply the command to the held state
  always_comb begin
    hit    = 1'b0;
    passed = 1'b0;
    busy   = (held_mod_r != '0) || (sent_mod_r != '0);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held_nxt[i] = held_r[i];
      if (held_r[i] == cmd.usage) begin
        hit = 1'b1;
      end
      if ((held_r[i] != '0) || (sent_r[i] != '0)) begin
        busy = 1'b1;
      end
    end
    held_mod_nxt = held_mod_r;
    case (cmd.op)
      kbr_pkg::CMD_MOD: begin
        held_mod_nxt = cmd.down ? (held_mod_r | mod_bit) : (held_mod_r & ~mod_bit);
      end
      kbr_pkg::CMD_PRESS: begin
        // Fill the first empty slot; held slots are always packed
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (!hit && (held_r[i] == '0) &&
              ((i == 0) || (held_r[(i == 0) ? 0 : i - 1] != '0))) begin
            held_nxt[i] = cmd.usage;
          end
        end
      end
      kbr_pkg::CMD_RELEASE: begin
        // Drop the matching slot and shift the rest down
        for (int i = 0; i < KEY_SLOTS; i++) begin
          if (held_r[i] == cmd.usage) begin
            passed = 1'b1;
          end
          if (passed) begin
            held_nxt[i] = (i < KEY_SLOTS - 1) ? held_r[(i < KEY_SLOTS - 1) ? i + 1 : i] : '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Compare the new held state with the last report
  always_comb begin
    differ = (held_mod_nxt != sent_mod_r);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (held_nxt[i] != sent_r[i]) begin
        differ = 1'b1;
      end
    end
  end

  // Decide tick count, sent state and report
  always_comb begin
    ticks_nxt      = ticks_r;
    sent_mod_nxt   = sent_mod_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    report_nxt     = report_r;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      sent_nxt[i] = sent_r[i];
    end
    if (run) begin
      if (cmd.op == kbr_pkg::CMD_TICK) begin
        ticks_nxt = ticks_inc;
        if ((ticks_inc > timeout_r) && busy) begin
          ticks_nxt     = '0;
          sent_mod_nxt  = '0;
          out_valid_nxt = 1'b1;
          report_nxt    = '0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            sent_nxt[i] = '0;
          end
        end
      end else if (can_send) begin
        ticks_nxt = '0;
        if (differ) begin
          sent_mod_nxt    = held_mod_nxt;
          out_valid_nxt   = 1'b1;
          report_nxt.mods = held_mod_nxt;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            sent_nxt[i] = held_nxt[i];
          end
          for (int i = 0; i < kbr_pkg::OUT_SLOTS; i++) begin
            report_nxt.keys[i] = (i < KEY_SLOTS) ? held_nxt[(i < KEY_SLOTS) ? i : 0] : '0;
          end
        end
      end
    end
  end

  // Hold configuration, state and the report slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= kbr_pkg::REPORT_INTERVAL_RST;
      timeout_r   <= kbr_pkg::STUCK_TIMEOUT_RST;
      held_mod_r  <= '0;
      sent_mod_r  <= '0;
      ticks_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        held_r[i] <= '0;
        sent_r[i] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index == kbr_pkg::CFG_REPORT_INTERVAL)) begin
        interval_r <= cfg_data[IW-1:0];
      end
      if (cfg_we && (cfg_index == kbr_pkg::CFG_STUCK_TIMEOUT)) begin
        timeout_r <= cfg_data[TW-1:0];
      end
      ticks_r     <= ticks_nxt;
      sent_mod_r  <= sent_mod_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        sent_r[i] <= sent_nxt[i];
      end
      if (run) begin
        if ((cmd.op == kbr_pkg::CMD_TICK) && (ticks_inc > timeout_r) && busy) begin
          held_mod_r <= '0;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            held_r[i] <= '0;
          end
        end else if (cmd.op != kbr_pkg::CMD_TICK) begin
          held_mod_r <= held_mod_nxt;
          for (int i = 0; i < KEY_SLOTS; i++) begin
            held_r[i] <= held_nxt[i];
          end
        end
      end
    end
  end

  // Report payload
  always_ff @(posedge clk) begin
    report_r <= report_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/keycode_to_hid_keyboard_report_core.sv =====
// ----------------------------------------------------------------------------
// Keycode to HID keyboard report core
// Builds 6KRO boot-keyboard reports from scan-code key events and ticks.
// ----------------------------------------------------------------------------
// Path: a beat is written into the command queue, and the back end then
// registers the report that it yields before it shows on the out_ ports.
// Throughput: one beat per cycle while in_full is low; the back end runs one command per cycle
// and stalls only while its single report register is full and not popped.
// A two-entry command queue separates translation from state update.
// Reset (rst_n low, synchronous) clears keys, tick count and queues and
// loads report_interval = 1000, stuck_timeout = 300000.
`default_nettype none

module keycode_to_hid_keyboard_report_core #(
  parameter int KEY_SLOTS = kbr_pkg::KEY_SLOTS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [kbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [kbr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic                             in_opcode,
  input  wire logic [kbr_pkg::SCAN_W-1:0]       in_scan_code,
  input  wire logic                             in_key_down,
  input  wire logic                             in_host_ready,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic [kbr_pkg::USAGE_W-1:0]           out_modifier_bits,
  output logic [kbr_pkg::USAGE_W-1:0]           out_key_slot0,
  output logic [kbr_pkg::USAGE_W-1:0]           out_key_slot1,
  output logic [kbr_pkg::USAGE_W-1:0]           out_key_slot2,
  output logic [kbr_pkg::USAGE_W-1:0]           out_key_slot3,
  output logic [kbr_pkg::USAGE_W-1:0]           out_key_slot4,
  output logic [kbr_pkg::USAGE_W-1:0]           out_key_slot5
);

  kbr_pkg::cmd_t    front_cmd, back_cmd;
  logic             front_push, cmd_valid, cmd_pop;
  kbr_pkg::report_t report;

  // Classify input beats
  kbr_front u_front (
    .in_opcode     (in_opcode),
    .in_scan_code  (in_scan_code),
    .in_key_down   (in_key_down),
    .in_host_ready (in_host_ready),
    .in_beat       (in_push && !in_full),
    .cmd           (front_cmd),
    .cmd_push      (front_push)
  );

  // Queue commands
  kbr_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (cmd_pop),
    .pop_data  (back_cmd),
    .valid     (cmd_valid)
  );

  // Execute commands
  kbr_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (back_cmd),
    .cmd_pop   (cmd_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .report    (report)
  );

  // Unpack the report
  assign out_modifier_bits = report.mods;
  assign out_key_slot0     = report.keys[0];
  assign out_key_slot1     = report.keys[1];
  assign out_key_slot2     = report.keys[2];
  assign out_key_slot3     = report.keys[3];
  assign out_key_slot4     = report.keys[4];
  assign out_key_slot5     = report.keys[5];

endmodule

`default_nettype wire
